FILE: rtl/core/brlp_pkg.sv
`timescale 1ns / 1ps

package brlp_pkg;

  typedef enum logic [1:0] {
    PH_EXPECT,
    PH_SIGN,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } brlp_item_t;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [6:0] NUM_SAT    = 7'd127;

  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[CHAR_ZERO:CHAR_NINE]});
  endfunction

endpackage

FILE: rtl/core/brlp_parser.sv
`timescale 1ns / 1ps

module brlp_parser
  import brlp_pkg::*;
#(
  parameter int MASK_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  brlp_item_t           item,
  output logic [MASK_BITS-1:0] res_mask,
  output logic                 res_err
);

  localparam int SHW = $clog2(MASK_BITS);

  phase_t               phase;
  phase_t               phase_a;
  phase_t               phase_next;
  logic [6:0]           number_accum;
  logic [6:0]           num_a;
  logic [6:0]           number_accum_next;
  logic                 number_negative;
  logic                 neg_a;
  logic                 number_negative_next;
  logic [SHW-1:0]       range_low;
  logic [SHW-1:0]       range_low_next;
  logic                 range_pending;
  logic                 range_pending_next;
  logic [MASK_BITS-1:0] mask_accum;
  logic [MASK_BITS-1:0] mask_accum_next;
  logic                 error_flag;
  logic                 error_flag_next;

  logic [7:0]           c;
  logic                 has_char;
  logic                 digit;
  logic [3:0]           dval;
  logic [10:0]          num_sum;
  logic                 mid_fin;
  logic                 ends;
  logic                 fin;
  logic                 bad;
  logic                 opens_range;
  logic [MASK_BITS-1:0] toggle;
  logic [MASK_BITS-1:0] mask_b;
  logic                 err_b;

  assign c        = item.text_byte;
  assign has_char = (c != CHAR_NUL);
  assign digit    = is_digit(c);
  assign dval     = 4'(c - CHAR_ZERO);
  assign num_sum  = 11'(number_accum) * 11'd10 + 11'(dval);
  assign mid_fin  = has_char && (phase == PH_DIGITS) && !digit;
  assign ends     = !has_char || item.is_last;

  // Phase and number after the character itself, before any entry completes.
  always_comb begin
    phase_a = phase;
    num_a   = number_accum;
    neg_a   = number_negative;
    if (has_char) begin
      case (phase)
        PH_EXPECT: begin
          if (is_blank(c)) begin
            phase_a = PH_EXPECT;
          end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
            neg_a   = (c == CHAR_DASH);
            phase_a = PH_SIGN;
          end else if (digit) begin
            neg_a   = 1'b0;
            num_a   = 7'(dval);
            phase_a = PH_DIGITS;
          end else begin
            phase_a = PH_STOP;
          end
        end
        PH_SIGN: begin
          if (digit) begin
            num_a   = 7'(dval);
            phase_a = PH_DIGITS;
          end else begin
            phase_a = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            num_a = (num_sum > 11'(NUM_SAT)) ? NUM_SAT : num_sum[6:0];
          end else if (c == CHAR_COMMA || c == CHAR_DASH || is_blank(c)) begin
            phase_a = PH_EXPECT;
          end else if (c == CHAR_PLUS) begin
            phase_a = PH_SIGN;
          end else begin
            phase_a = PH_STOP;
          end
        end
        default: begin
          phase_a = PH_STOP;
        end
      endcase
    end
  end

  assign fin = mid_fin || (ends && phase_a == PH_DIGITS);
  assign bad = (neg_a && num_a != 7'd0) || (num_a >= 7'(MASK_BITS));
  assign opens_range = mid_fin && !bad && (c == CHAR_DASH);

  always_comb begin
    if (range_pending) begin
      toggle = (MASK_BITS'(2) << num_a[SHW-1:0]) - (MASK_BITS'(2) << range_low);
    end else begin
      toggle = MASK_BITS'(1) << num_a[SHW-1:0];
    end
  end

  assign mask_b = (fin && !bad) ? (mask_accum ^ toggle) : mask_accum;
  assign err_b  = error_flag | (fin && bad);

  always_comb begin
    phase_next = phase;
    if (step) begin
      if (ends) begin
        phase_next = PH_EXPECT;
      end else if (fin && bad) begin
        phase_next = PH_STOP;
      end else begin
        phase_next = phase_a;
      end
    end
  end

  always_comb begin
    mask_accum_next      = mask_accum;
    error_flag_next      = error_flag;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    range_low_next       = range_low;
    range_pending_next   = range_pending;
    if (step) begin
      if (ends) begin
        mask_accum_next      = '0;
        error_flag_next      = 1'b0;
        number_accum_next    = '0;
        number_negative_next = 1'b0;
        range_low_next       = '0;
        range_pending_next   = 1'b0;
      end else begin
        mask_accum_next      = mask_b;
        error_flag_next      = err_b;
        number_accum_next    = num_a;
        number_negative_next = (mid_fin && c == CHAR_PLUS) ? 1'b0 : neg_a;
        if (opens_range) begin
          range_low_next     = num_a[SHW-1:0];
          range_pending_next = 1'b1;
        end else if (fin) begin
          range_pending_next = 1'b0;
        end
      end
    end
  end

  assign res_mask = mask_b;
  assign res_err  = err_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_EXPECT;
      mask_accum      <= '0;
      error_flag      <= 1'b0;
      number_accum    <= '0;
      number_negative <= 1'b0;
      range_low       <= '0;
      range_pending   <= 1'b0;
    end else begin
      phase           <= phase_next;
      mask_accum      <= mask_accum_next;
      error_flag      <= error_flag_next;
      number_accum    <= number_accum_next;
      number_negative <= number_negative_next;
      range_low       <= range_low_next;
      range_pending   <= range_pending_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOP && step && !ends) |=> (phase == PH_STOP))
    else $error("A stopped parse resumed before the end of the string.");

  assert property (@(posedge clk) disable iff (rst)
    (error_flag && step && !ends) |=> error_flag)
    else $error("The error flag cleared within a string.");

  assert property (@(posedge clk) disable iff (rst)
    (step && ends) |=> (mask_accum == '0 && !error_flag && !range_pending))
    else $error("Parse state was not cleared after the end of a string.");

endmodule

FILE: rtl/core/bit_range_list_parser.sv
`timescale 1ns / 1ps

// Parses a bit list such as "1,12,3-6,9" one character per transfer and
// returns a mask in which every listed bit or range of bits is toggled.
// The input channel (in_valid, in_stall) carries text_byte and is_last.
// A zero byte, or any byte with is_last set, ends the string; the output
// channel (out_valid, out_stall) then delivers one result with bit_mask
// and range_error, and the parse state returns to its reset value.
// Bytes that do not end a string produce no result.
// Each transfer is captured in an input register and processed from
// there; the last byte's result is then captured in the result register,
// which raises out_valid. One byte is accepted every cycle while in_stall
// is low.
// While out_stall holds a result, bytes that produce no result keep
// flowing; a byte that ends the next string waits in the input register
// and in_stall rises until the result register is free.
// Reset is synchronous: both registers empty and the parse state clears.
// Bits of bit_mask at or above MASK_BITS are always zero.
module bit_range_list_parser
  import brlp_pkg::*;
#(
  parameter int MASK_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] bit_mask,
  output logic        range_error
);

  logic                 held;
  brlp_item_t           item_q;
  logic                 item_ends;
  logic                 fire;
  logic                 accept;
  logic [MASK_BITS-1:0] res_mask;
  logic                 res_err;
  logic [MASK_BITS-1:0] mask_q;
  logic                 err_q;

  assign item_ends = (item_q.text_byte == CHAR_NUL) || item_q.is_last;
  assign fire      = held && (!item_ends || !out_valid || !out_stall);
  assign in_stall  = held && !fire;
  assign accept    = in_valid && !in_stall;

  brlp_parser #(
    .MASK_BITS(MASK_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (fire),
    .item     (item_q),
    .res_mask (res_mask),
    .res_err  (res_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        held <= 1'b1;
      end else if (fire) begin
        held <= 1'b0;
      end
      if (fire && item_ends) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.text_byte <= text_byte;
      item_q.is_last   <= is_last;
    end
    if (fire && item_ends) begin
      mask_q <= res_mask;
      err_q  <= res_err;
    end
  end

  assign bit_mask    = 64'(mask_q);
  assign range_error = err_q;

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held && item_ends))
    else $error("Input stalled without a pending end of string.");

  assert property (@(posedge clk) disable iff (rst)
    (fire && item_ends) |=> out_valid)
    else $error("A finished string did not produce a result.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("A stalled result was dropped.");

  assert property (@(posedge clk)
    rst |=> (!held && !out_valid))
    else $error("Registers were not empty after reset.");

endmodule

FILE: bench/tb_bit_range_list_parser.sv
`timescale 1ns / 1ps

module tb_bit_range_list_parser;
  import brlp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 375;

  class mask_scoreboard;
    logic [63:0] mask_acc;
    logic [6:0]  num_acc;
    logic [5:0]  range_lo;
    bit          num_neg;
    bit          range_pend;
    bit          err_flag;
    phase_t      phase;
    logic [63:0] mask_q[$];
    bit          err_q[$];
    int          mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      mask_acc = '0;
      num_acc = '0;
      range_lo = '0;
      num_neg = 1'b0;
      range_pend = 1'b0;
      err_flag = 1'b0;
      phase = PH_EXPECT;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // A number out of range toggles nothing and stops the parse.
    function bit close_number();
      logic [63:0] hi;
      logic [63:0] lo;
      if ((num_neg && num_acc != 0) || num_acc >= 7'd64) begin
        err_flag = 1'b1;
        phase = PH_STOP;
        range_pend = 1'b0;
        return 1'b0;
      end
      if (range_pend) begin
        hi = 64'd2 << num_acc;
        lo = 64'd2 << range_lo;
        mask_acc ^= hi - lo;
      end else begin
        mask_acc ^= 64'd1 << num_acc;
      end
      range_pend = 1'b0;
      return 1'b1;
    endfunction

    function void step_char(logic [7:0] c);
      int v;
      logic [6:0] low_end;
      case (phase)
        PH_EXPECT: begin
          if (blank_char(c)) begin
          end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
            num_neg = (c == CHAR_DASH);
            phase = PH_SIGN;
          end else if (digit_char(c)) begin
            num_neg = 1'b0;
            num_acc = {3'b000, c[3:0]};
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOP;
          end
        end
        PH_SIGN: begin
          if (digit_char(c)) begin
            num_acc = {3'b000, c[3:0]};
            phase = PH_DIGITS;
          end else begin
            phase = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (digit_char(c)) begin
            v = int'(num_acc) * 10 + int'(c[3:0]);
            num_acc = (v > int'(NUM_SAT)) ? NUM_SAT : v[6:0];
          end else begin
            low_end = num_acc;
            if (close_number()) begin
              if (c == CHAR_COMMA || blank_char(c)) begin
                phase = PH_EXPECT;
              end else if (c == CHAR_DASH) begin
                range_lo = low_end[5:0];
                range_pend = 1'b1;
                phase = PH_EXPECT;
              end else if (c == CHAR_PLUS) begin
                num_neg = 1'b0;
                phase = PH_SIGN;
              end else begin
                phase = PH_STOP;
              end
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] c, bit last);
      if (c != CHAR_NUL) step_char(c);
      if (c != CHAR_NUL && !last) return;
      if (phase == PH_DIGITS) void'(close_number());
      mask_q.push_back(mask_acc);
      err_q.push_back(err_flag);
      clear();
    endfunction

    function void check_result(logic [63:0] m, logic e);
      logic [63:0] want_mask;
      bit want_err;
      if (mask_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result mask=%h error=%b", $time, m, e);
        return;
      end
      want_mask = mask_q.pop_front();
      want_err = err_q.pop_front();
      if (m !== want_mask || e !== want_err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch mask exp=%h got=%h error exp=%b got=%b",
                   $time, want_mask, m, want_err, e);
      end
    endfunction

    function int pending();
      return mask_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  text_byte;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] bit_mask;
  logic        range_error;

  mask_scoreboard sb;
  logic [7:0] list_text[$];
  int send_pct;
  int recv_pct;
  int phase_bytes;
  int quiet_cycles;

  bit_range_list_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .is_last(is_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bit_mask(bit_mask),
    .range_error(range_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(text_byte, is_last);
      if (out_valid && !out_stall) sb.check_result(bit_mask, range_error);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input bit last);
    int gap;
    gap = 0;
    while (send_pct != 0 && $urandom_range(99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= c;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit flag_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], flag_end && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'h20 : 8'h09 + r[7:0];
  endfunction

  function automatic int pick_bit();
    int r;
    r = $urandom_range(19);
    if (r == 0) return $urandom_range(999);
    if (r == 1) return 63;
    if (r == 2) return 0;
    return $urandom_range(63);
  endfunction

  function automatic void add_number(int v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(15) == 0) list_text.push_back(CHAR_ZERO);
    for (int i = 0; i < digits.len(); i++) list_text.push_back(digits[i]);
  endfunction

  // Mostly well-formed lists of bits and ranges; some get a random byte.
  function automatic void build_list();
    int entries;
    int r;
    list_text.delete();
    entries = $urandom_range(0, 6);
    for (int e = 0; e < entries; e++) begin
      if ($urandom_range(7) == 0) list_text.push_back(pick_blank());
      r = $urandom_range(19);
      if (r == 0) list_text.push_back(CHAR_PLUS);
      else if (r == 1) list_text.push_back(CHAR_DASH);
      add_number(pick_bit());
      if ($urandom_range(2) == 0) begin
        list_text.push_back(CHAR_DASH);
        if ($urandom_range(11) != 0) add_number(pick_bit());
      end
      if (e < entries - 1) begin
        r = $urandom_range(9);
        if (r == 0) list_text.push_back(pick_blank());
        else if (r == 1) list_text.push_back(CHAR_PLUS);
        else list_text.push_back(CHAR_COMMA);
      end
    end
    if ($urandom_range(9) == 0) list_text.push_back(pick_blank());
    if ($urandom_range(7) == 0) begin
      if (list_text.size() > 0 && $urandom_range(1) == 0)
        list_text[$urandom_range(list_text.size() - 1)] = 8'($urandom_range(255));
      else
        list_text.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_list();
    bit flag_end;
    build_list();
    flag_end = (list_text.size() > 0) && ($urandom_range(1) == 0);
    for (int i = 0; i < list_text.size(); i++)
      send_byte(list_text[i], flag_end && i == list_text.size() - 1);
    if (!flag_end) send_byte(CHAR_NUL, 1'($urandom_range(1)));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    text_byte = 8'h00;
    is_last = 1'b0;
    send_pct = 0;
    recv_pct = 0;
    quiet_cycles = 0;
    phase_bytes = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text("1,3-6", 1'b1);
    send_text("-0 200", 1'b0);
    send_byte(CHAR_NUL, 1'b0);
    send_text("9-2-", 1'b1);
    send_text("63+,", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("-5", 1'b0);
    send_byte(CHAR_NUL, 1'b1);
    send_text(",1", 1'b1);
    send_byte(CHAR_NUL, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 83; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 83; end
        default: begin send_pct = 7; recv_pct = 7; end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_list();
        if ($urandom_range(30) == 0) wait_drained();
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
